// ----- rtl/bsfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfa_pkg
// Types and constants shared by the switch feedback admission block.
// ----------------------------------------------------------------------------
package bsfa_pkg;

  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = 2;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = 3;

  localparam logic       KIND_ARRIVAL = 1'b0;
  localparam logic       KIND_DEPART  = 1'b1;

  localparam logic [1:0] VERDICT_ADMIT  = 2'd0;
  localparam logic [1:0] VERDICT_DROP   = 2'd1;
  localparam logic [1:0] VERDICT_DEPART = 2'd2;

  localparam logic [1:0] REG_MAX_QUEUE = 2'd0;
  localparam logic [1:0] REG_CC_THRESH = 2'd1;
  localparam logic [1:0] REG_MTU       = 2'd2;
  localparam logic [1:0] REG_RATE      = 2'd3;

  localparam logic [23:0] MAX_QUEUE_RESET = 24'd1048576;
  localparam logic [23:0] CC_THRESH_RESET = 24'd1500;
  localparam logic [13:0] MTU_RESET       = 14'd1500;
  localparam logic [31:0] RATE_RESET      = 32'd53687091;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PRU_ADD,
    ACT_INC
  } act_t;

  typedef struct packed {
    logic        kind;
    logic [13:0] pkt_bytes;
    logic        is_data;
    logic        fb_already_sent;
    logic        last_of_flow;
    logic        first_window;
    logic        inc_request;
    logic [47:0] arrival_time;
  } in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        send_feedback;
    logic [23:0] feedback_queue_bytes;
    logic [47:0] feedback_tx_bytes;
    logic [47:0] feedback_time;
    logic        inc_granted;
    logic [23:0] queue_bytes_after;
  } out_t;

  typedef struct packed {
    logic [23:0] max_queue_bytes;
    logic [23:0] cc_threshold_bytes;
    logic [13:0] mtu_bytes;
    logic [31:0] supply_rate;
  } cfg_t;

  // One classified word handed from the admission side to the token side.
  typedef struct packed {
    out_t        res;
    logic        refresh;
    act_t        act;
    logic [13:0] pkt_bytes;
    logic [47:0] elapsed;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- rtl/bsfa_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfa_front
// Admission side: queue occupancy, drops, sent bytes, feedback decision and
// classification of the token action for each accepted word.
// ----------------------------------------------------------------------------
module bsfa_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  bsfa_pkg::in_t  item,
  input  bsfa_pkg::cfg_t cfg,
  output bsfa_pkg::work_t work
);

  logic [23:0] queue_bytes;
  logic [47:0] sent_bytes;
  logic [47:0] last_supply_time;
  logic [31:0] drop_count;
  logic [23:0] peak_queue_bytes;

  logic        depart;
  logic        drop;
  logic        admit;
  logic        data_admit;
  logic        fb;
  logic [24:0] q_sum;
  logic [23:0] q_drain;
  logic [23:0] queue_bytes_next;

  always_comb begin
    depart     = (item.kind == bsfa_pkg::KIND_DEPART);
    q_sum      = {1'b0, queue_bytes} + {11'b0, item.pkt_bytes};
    drop       = !depart && (q_sum > {1'b0, cfg.max_queue_bytes});
    admit      = !depart && !drop;
    data_admit = admit && item.is_data;
    fb         = data_admit && !item.fb_already_sent &&
                 (queue_bytes > cfg.cc_threshold_bytes);
    q_drain    = (queue_bytes > {10'b0, item.pkt_bytes}) ?
                 queue_bytes - {10'b0, item.pkt_bytes} : 24'd0;

    if (admit) begin
      queue_bytes_next = q_sum[23:0];
    end else if (depart) begin
      queue_bytes_next = q_drain;
    end else begin
      queue_bytes_next = queue_bytes;
    end

    work.refresh   = data_admit;
    work.pkt_bytes = item.pkt_bytes;
    work.elapsed   = item.arrival_time - last_supply_time;
    if (!data_admit || fb) begin
      work.act = bsfa_pkg::ACT_NONE;
    end else if (item.last_of_flow && !item.first_window) begin
      work.act = bsfa_pkg::ACT_PRU_ADD;
    end else if (item.inc_request) begin
      work.act = bsfa_pkg::ACT_INC;
    end else begin
      work.act = bsfa_pkg::ACT_NONE;
    end

    if (depart) begin
      work.res.verdict = bsfa_pkg::VERDICT_DEPART;
    end else if (drop) begin
      work.res.verdict = bsfa_pkg::VERDICT_DROP;
    end else begin
      work.res.verdict = bsfa_pkg::VERDICT_ADMIT;
    end
    work.res.send_feedback        = fb;
    work.res.feedback_queue_bytes = fb ? queue_bytes : 24'd0;
    work.res.feedback_tx_bytes    = fb ? sent_bytes : 48'd0;
    work.res.feedback_time        = fb ? item.arrival_time : 48'd0;
    work.res.inc_granted          = admit && item.inc_request;
    work.res.queue_bytes_after    = queue_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_bytes      <= '0;
      sent_bytes       <= '0;
      last_supply_time <= '0;
      drop_count       <= '0;
      peak_queue_bytes <= '0;
    end else if (accept) begin
      queue_bytes <= queue_bytes_next;
      if (depart) begin
        sent_bytes <= sent_bytes + {34'b0, item.pkt_bytes};
      end
      if (drop) begin
        drop_count <= drop_count + 32'd1;
      end
      if (data_admit) begin
        last_supply_time <= item.arrival_time;
      end
      if (admit && (queue_bytes_next > peak_queue_bytes)) begin
        peak_queue_bytes <= queue_bytes_next;
      end
    end
  end

endmodule

// ----- rtl/bsfa_work_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfa_work_queue
// Short queue of classified words between the admission and token sides.
// ----------------------------------------------------------------------------
module bsfa_work_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  bsfa_pkg::work_t  wr_data,
  input  logic             rd_en,
  output bsfa_pkg::work_t  rd_data,
  output bsfa_pkg::qstat_t stat
);

  bsfa_pkg::work_t               mem [bsfa_pkg::MID_DEPTH];
  logic [bsfa_pkg::MID_AW-1:0]   wptr;
  logic [bsfa_pkg::MID_AW-1:0]   rptr;
  logic [bsfa_pkg::MID_AW:0]     count;

  assign rd_data    = mem[rptr];
  assign stat.full  = (count == (bsfa_pkg::MID_AW + 1)'(bsfa_pkg::MID_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/bsfa_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfa_back
// Token side: supply multiply over two stages, then the supply and PRU
// token update, and the result queue toward the consumer.
// ----------------------------------------------------------------------------
module bsfa_back (
  input  logic             clk,
  input  logic             rst,
  input  bsfa_pkg::cfg_t   cfg,
  input  bsfa_pkg::qstat_t mid_stat,
  input  bsfa_pkg::work_t  mid_data,
  output logic             mid_rd,
  input  logic             pop,
  output logic             empty,
  output bsfa_pkg::out_t   result
);

  // Multiply stage.
  logic            a_valid;
  bsfa_pkg::work_t a_work;
  logic [47:0]     a_phi;
  logic [63:0]     a_plo;

  // Supply sum stage.
  logic            b_valid;
  bsfa_pkg::work_t b_work;
  logic [48:0]     b_supply;

  logic signed [31:0] supply_tokens;
  logic [15:0]        pru_count;

  bsfa_pkg::out_t              oq [bsfa_pkg::OUT_DEPTH];
  logic [bsfa_pkg::OUT_AW-1:0] oq_wptr;
  logic [bsfa_pkg::OUT_AW-1:0] oq_rptr;
  logic [bsfa_pkg::OUT_AW:0]   oq_count;
  logic [bsfa_pkg::OUT_AW+1:0] committed;
  logic                        oq_pop;

  logic signed [50:0] t_sum;
  logic signed [50:0] t_clip;
  logic signed [50:0] mtu_wide;
  logic signed [50:0] low_wide;
  logic signed [31:0] tok_ref;
  logic signed [31:0] mtu_32;
  logic signed [31:0] supply_tokens_next;
  logic [15:0]        pru_count_next;
  bsfa_pkg::out_t     res_c;

  // A word leaves the middle queue only when the result queue is sure to
  // have room for it, so the stages below never stall.
  assign committed = {1'b0, oq_count} + {{bsfa_pkg::OUT_AW{1'b0}}, 1'b0, a_valid}
                   + {{bsfa_pkg::OUT_AW{1'b0}}, 1'b0, b_valid};
  assign mid_rd    = !mid_stat.empty &&
                     (committed < (bsfa_pkg::OUT_AW + 2)'(bsfa_pkg::OUT_DEPTH));

  assign empty  = (oq_count == '0);
  assign result = oq[oq_rptr];
  assign oq_pop = pop && !empty;

  always_comb begin
    mtu_wide = {37'b0, cfg.mtu_bytes};
    low_wide = {{20{1'b1}}, 31'b0};
    mtu_32   = {18'b0, cfg.mtu_bytes};
    t_sum    = {{19{supply_tokens[31]}}, supply_tokens} + {2'b0, b_supply}
             - {37'b0, b_work.pkt_bytes};
    if (t_sum > mtu_wide) begin
      t_clip = mtu_wide;
    end else if (t_sum < low_wide) begin
      t_clip = low_wide;
    end else begin
      t_clip = t_sum;
    end
    tok_ref = b_work.refresh ? t_clip[31:0] : supply_tokens;

    supply_tokens_next = tok_ref;
    pru_count_next     = pru_count;
    res_c              = b_work.res;
    case (b_work.act)
      bsfa_pkg::ACT_PRU_ADD: begin
        if (pru_count != 16'hFFFF) begin
          pru_count_next = pru_count + 16'd1;
        end
      end
      bsfa_pkg::ACT_INC: begin
        if (pru_count != 16'd0) begin
          pru_count_next = pru_count - 16'd1;
        end else if (tok_ref >= mtu_32) begin
          supply_tokens_next = tok_ref - mtu_32;
        end else begin
          res_c.inc_granted = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_work   <= mid_data;
    a_phi    <= {32'b0, mid_data.elapsed[47:32]} * {16'b0, cfg.supply_rate};
    a_plo    <= {32'b0, mid_data.elapsed[31:0]} * {32'b0, cfg.supply_rate};
    b_work   <= a_work;
    b_supply <= {1'b0, a_phi} + {17'b0, a_plo[63:32]};
    if (b_valid) begin
      oq[oq_wptr] <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      supply_tokens <= '0;
      pru_count     <= '0;
      oq_wptr       <= '0;
      oq_rptr       <= '0;
      oq_count      <= '0;
    end else begin
      a_valid <= mid_rd;
      b_valid <= a_valid;
      if (b_valid) begin
        supply_tokens <= supply_tokens_next;
        pru_count     <= pru_count_next;
        oq_wptr       <= oq_wptr + 1'b1;
      end
      if (oq_pop) begin
        oq_rptr <= oq_rptr + 1'b1;
      end
      if (b_valid && !oq_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (oq_pop && !b_valid) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/bolt_switch_feedback_admission.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bolt_switch_feedback_admission
// Switch port queue accounting with early congestion feedback and
// supply/PRU token handling for window increments.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        item   (bsfa_pkg::in_t)
//  result    pop / empty        result (bsfa_pkg::out_t)
//  config    cfg_we             cfg_index, cfg_data
//
// One word is accepted per cycle while full is low. An accepted word is
// written into the work queue, then passes through the supply multiply
// stage and the supply sum stage, and the token update writes its result
// into the result queue.
// Reset is synchronous; it clears counters, pointers and tokens. full rises
// when the work queue holds four words, which happens only once the result
// queue and the two stages ahead of it hold eight words between them.
// ----------------------------------------------------------------------------
module bolt_switch_feedback_admission (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  bsfa_pkg::in_t  item,
  input  logic           pop,
  output logic           empty,
  output bsfa_pkg::out_t result,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  bsfa_pkg::cfg_t   cfg;
  bsfa_pkg::work_t  front_work;
  bsfa_pkg::work_t  mid_data;
  bsfa_pkg::qstat_t mid_stat;
  logic             accept;
  logic             mid_rd;

  assign full   = mid_stat.full;
  assign accept = push && !mid_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_queue_bytes    <= bsfa_pkg::MAX_QUEUE_RESET;
      cfg.cc_threshold_bytes <= bsfa_pkg::CC_THRESH_RESET;
      cfg.mtu_bytes          <= bsfa_pkg::MTU_RESET;
      cfg.supply_rate        <= bsfa_pkg::RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsfa_pkg::REG_MAX_QUEUE: cfg.max_queue_bytes    <= cfg_data[23:0];
        bsfa_pkg::REG_CC_THRESH: cfg.cc_threshold_bytes <= cfg_data[23:0];
        bsfa_pkg::REG_MTU:       cfg.mtu_bytes          <= cfg_data[13:0];
        bsfa_pkg::REG_RATE:      cfg.supply_rate        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bsfa_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .work   (front_work)
  );

  bsfa_work_queue u_work_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_work),
    .rd_en   (mid_rd),
    .rd_data (mid_data),
    .stat    (mid_stat)
  );

  bsfa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .mid_stat (mid_stat),
    .mid_data (mid_data),
    .mid_rd   (mid_rd),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

// ----- verif/bolt_switch_feedback_admission_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bolt_switch_feedback_admission_tb
// Drives arrival and departure words into the switch port accounting block
// with random gaps on both queues and checks every result word against an
// in-bench model of occupancy, sent bytes, supply and PRU tokens. The run
// covers directed corner cases, a burst of PRU deposits and random
// traffic under several register settings.
// ----------------------------------------------------------------------------
module bolt_switch_feedback_admission_tb;

  localparam int unsigned STALL_LIMIT = 500;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            push = 1'b0;
  logic            full;
  bsfa_pkg::in_t   item = '0;
  logic            pop = 1'b0;
  logic            empty;
  bsfa_pkg::out_t  result;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_index = bsfa_pkg::REG_MAX_QUEUE;
  logic [31:0]     cfg_data = '0;

  bolt_switch_feedback_admission u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .pop       (pop),
    .empty     (empty),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Register copies as the block should hold them.
  logic [23:0] cap_bytes = bsfa_pkg::MAX_QUEUE_RESET;
  logic [23:0] fb_thresh = bsfa_pkg::CC_THRESH_RESET;
  logic [13:0] mtu_sz    = bsfa_pkg::MTU_RESET;
  logic [31:0] rate_fx   = bsfa_pkg::RATE_RESET;

  // Port state as the block should hold it.
  logic [23:0]        occ_bytes    = '0;
  logic [47:0]        tx_total     = '0;
  logic signed [63:0] supply_tok   = '0;
  logic [15:0]        pru_cnt      = '0;
  logic [47:0]        supply_stamp = '0;
  logic [31:0]        drop_cnt     = '0;
  logic [23:0]        peak_occ     = '0;

  bsfa_pkg::in_t  queued_events[$];
  bsfa_pkg::out_t awaited_results[$];
  bsfa_pkg::out_t want;
  int unsigned n_fail = 0;

  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  logic        tx_calm = 1'b0;
  logic        rx_calm = 1'b0;
  logic        hurry = 1'b0;
  int unsigned idle_cycles = 0;

  // Stimulus generator state.
  int unsigned est_occ = 0;
  int unsigned gen_cap = 0;
  int unsigned gen_size_max = 0;
  logic [47:0] gen_time = '0;

  function automatic bsfa_pkg::out_t account_word(bsfa_pkg::in_t w);
    bsfa_pkg::out_t     r;
    logic [47:0]        elapsed;
    logic [79:0]        prod;
    logic signed [63:0] tok;
    logic signed [63:0] mtu_limit;
    r = '0;
    mtu_limit = $signed({50'd0, mtu_sz});
    if (w.kind == bsfa_pkg::KIND_DEPART) begin
      occ_bytes = (occ_bytes > {10'd0, w.pkt_bytes}) ?
                  occ_bytes - {10'd0, w.pkt_bytes} : 24'd0;
      tx_total = tx_total + {34'd0, w.pkt_bytes};
      r.verdict = bsfa_pkg::VERDICT_DEPART;
    end else if (({1'b0, occ_bytes} + {11'd0, w.pkt_bytes}) > {1'b0, cap_bytes}) begin
      drop_cnt = drop_cnt + 32'd1;
      r.verdict = bsfa_pkg::VERDICT_DROP;
    end else begin
      r.verdict = bsfa_pkg::VERDICT_ADMIT;
      r.inc_granted = w.inc_request;
      if (w.is_data) begin
        // Supply is elapsed picoseconds times the 32-fraction-bit rate, floored.
        elapsed = w.arrival_time - supply_stamp;
        prod = {32'd0, elapsed} * {48'd0, rate_fx};
        tok = supply_tok + $signed({16'd0, prod[79:32]}) - $signed({50'd0, w.pkt_bytes});
        if (tok > mtu_limit) tok = mtu_limit;
        if (tok < -64'sd2147483648) tok = -64'sd2147483648;
        supply_tok = tok;
        supply_stamp = w.arrival_time;
        if (!w.fb_already_sent && occ_bytes > fb_thresh) begin
          r.send_feedback = 1'b1;
          r.feedback_queue_bytes = occ_bytes;
          r.feedback_tx_bytes = tx_total;
          r.feedback_time = w.arrival_time;
        end else if (w.last_of_flow && !w.first_window) begin
          if (pru_cnt != 16'hFFFF) pru_cnt = pru_cnt + 16'd1;
        end else if (w.inc_request) begin
          if (pru_cnt != 16'd0) begin
            pru_cnt = pru_cnt - 16'd1;
          end else if (supply_tok >= mtu_limit) begin
            supply_tok = supply_tok - mtu_limit;
          end else begin
            r.inc_granted = 1'b0;
          end
        end
      end
      occ_bytes = occ_bytes + {10'd0, w.pkt_bytes};
      if (occ_bytes > peak_occ) peak_occ = occ_bytes;
    end
    r.queue_bytes_after = occ_bytes;
    return r;
  endfunction

  function automatic bsfa_pkg::in_t make_event(logic kind, logic [13:0] sz, logic dat,
                                               logic fbs, logic last, logic first,
                                               logic inc, logic [47:0] t);
    bsfa_pkg::in_t w;
    w.kind = kind;
    w.pkt_bytes = sz;
    w.is_data = dat;
    w.fb_already_sent = fbs;
    w.last_of_flow = last;
    w.first_window = first;
    w.inc_request = inc;
    w.arrival_time = t;
    return w;
  endfunction

  function automatic bsfa_pkg::in_t draw_event();
    bsfa_pkg::in_t w;
    int unsigned roll;
    w = '0;
    roll = $urandom_range(0, 99);
    // Lean toward departures once the queue sits in its upper quarter.
    if (est_occ > (gen_cap >> 1) + (gen_cap >> 2)) begin
      w.kind = (roll < 60) ? bsfa_pkg::KIND_DEPART : bsfa_pkg::KIND_ARRIVAL;
    end else begin
      w.kind = (roll < 35) ? bsfa_pkg::KIND_DEPART : bsfa_pkg::KIND_ARRIVAL;
    end
    case ($urandom_range(0, 15))
      0: w.pkt_bytes = '0;
      1: w.pkt_bytes = 14'h3FFF;
      default: w.pkt_bytes = 14'($urandom_range(0, gen_size_max));
    endcase
    w.is_data = ($urandom_range(0, 6) != 0);
    w.fb_already_sent = 1'($urandom_range(0, 1));
    w.last_of_flow = ($urandom_range(0, 3) == 0);
    w.first_window = 1'($urandom_range(0, 1));
    w.inc_request = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 39))
      0: gen_time = 48'({$urandom(), $urandom()});
      1: gen_time = gen_time - 48'($urandom_range(0, 500000));
      default: gen_time = gen_time + 48'($urandom_range(0, 250000));
    endcase
    w.arrival_time = gen_time;
    if (w.kind == bsfa_pkg::KIND_DEPART) begin
      est_occ = (est_occ > 32'(w.pkt_bytes)) ? est_occ - 32'(w.pkt_bytes) : 0;
    end else if (est_occ + 32'(w.pkt_bytes) <= gen_cap) begin
      est_occ = est_occ + 32'(w.pkt_bytes);
    end
    return w;
  endfunction

  task automatic check_field(input string name, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Waits until every word has been taken and answered, then lets the
  // pipeline settle before registers change.
  task automatic drain();
    while (queued_events.size() != 0 || push || awaited_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_port(input logic [23:0] mq, input logic [23:0] th,
                              input logic [13:0] mtu, input logic [31:0] rate);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= bsfa_pkg::REG_MAX_QUEUE;
    cfg_data <= {8'd0, mq};
    @(negedge clk);
    cfg_index <= bsfa_pkg::REG_CC_THRESH;
    cfg_data <= {8'd0, th};
    @(negedge clk);
    cfg_index <= bsfa_pkg::REG_MTU;
    cfg_data <= {18'd0, mtu};
    @(negedge clk);
    cfg_index <= bsfa_pkg::REG_RATE;
    cfg_data <= rate;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_bytes = mq;
    fb_thresh = th;
    mtu_sz = mtu;
    rate_fx = rate;
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned size_max);
    est_occ = 32'(occ_bytes);
    gen_cap = 32'(cap_bytes);
    gen_size_max = size_max;
    repeat (count) queued_events.push_back(draw_event());
  endtask

  // Sender: holds each word until it is taken, then waits its drawn gap.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      tx_wait <= 0;
    end else if (!push || in_fire) begin
      if (tx_wait != 0) begin
        push <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (queued_events.size() != 0) begin
        item <= queued_events.pop_front();
        push <= 1'b1;
        tx_wait <= (hurry || tx_calm) ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 39) == 0) tx_calm <= !tx_calm;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: pop stays high until a word is taken, then waits its gap.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_wait <= 0;
    end else if (!pop || out_fire) begin
      if (rx_wait != 0) begin
        pop <= 1'b0;
        rx_wait <= rx_wait - 1;
      end else begin
        pop <= 1'b1;
        rx_wait <= (hurry || rx_calm) ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 39) == 0) rx_calm <= !rx_calm;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_fire <= push && !full;
      out_fire <= pop && !empty;
      if (push && !full) awaited_results.push_back(account_word(item));
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          n_fail++;
          $display("%0t: result word with none expected, actual %h", $time, result);
        end else begin
          want = awaited_results.pop_front();
          check_field("verdict", 48'(want.verdict), 48'(result.verdict));
          check_field("send_feedback", 48'(want.send_feedback), 48'(result.send_feedback));
          check_field("feedback_queue_bytes", 48'(want.feedback_queue_bytes),
                      48'(result.feedback_queue_bytes));
          check_field("feedback_tx_bytes", want.feedback_tx_bytes, result.feedback_tx_bytes);
          check_field("feedback_time", want.feedback_time, result.feedback_time);
          check_field("inc_granted", 48'(want.inc_granted), 48'(result.inc_granted));
          check_field("queue_bytes_after", 48'(want.queue_bytes_after),
                      48'(result.queue_bytes_after));
        end
      end
      if ((push && !full) || (pop && !empty) ||
          (queued_events.size() == 0 && !push && awaited_results.size() == 0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words under the reset register values.
    queued_events.push_back(make_event(bsfa_pkg::KIND_ARRIVAL, 14'd0, 1'b1, 1'b0, 1'b0,
                                       1'b0, 1'b0, 48'd0));
    // No PRU token and negative supply: the increment is denied.
    queued_events.push_back(make_event(bsfa_pkg::KIND_ARRIVAL, 14'd1000, 1'b1, 1'b0, 1'b0,
                                       1'b0, 1'b1, 48'd100));
    queued_events.push_back(make_event(bsfa_pkg::KIND_ARRIVAL, 14'd1000, 1'b1, 1'b1, 1'b1,
                                       1'b0, 1'b0, 48'd200));
    // Last packet inside the first window falls through to the PRU grant.
    queued_events.push_back(make_event(bsfa_pkg::KIND_ARRIVAL, 14'd500, 1'b1, 1'b1, 1'b1,
                                       1'b1, 1'b1, 48'd300));
    queued_events.push_back(make_event(bsfa_pkg::KIND_ARRIVAL, 14'd800, 1'b1, 1'b0, 1'b0,
                                       1'b0, 1'b1, 48'd400));
    // A long gap fills supply to one MTU, which pays for the increment.
    queued_events.push_back(make_event(bsfa_pkg::KIND_ARRIVAL, 14'd800, 1'b1, 1'b1, 1'b0,
                                       1'b0, 1'b1, 48'd200000000));
    queued_events.push_back(make_event(bsfa_pkg::KIND_ARRIVAL, 14'd300, 1'b0, 1'b0, 1'b1,
                                       1'b0, 1'b1, 48'd200000100));
    queued_events.push_back(make_event(bsfa_pkg::KIND_ARRIVAL, 14'h3FFF, 1'b1, 1'b1, 1'b0,
                                       1'b0, 1'b0, 48'hFFFF_FFFF_FFFF));
    queued_events.push_back(make_event(bsfa_pkg::KIND_ARRIVAL, 14'd100, 1'b1, 1'b1, 1'b0,
                                       1'b0, 1'b1, 48'd5));
    queued_events.push_back(make_event(bsfa_pkg::KIND_ARRIVAL, 14'd100, 1'b1, 1'b1, 1'b0,
                                       1'b0, 1'b1, 48'd1));
    queued_events.push_back(make_event(bsfa_pkg::KIND_DEPART, 14'h3FFF, 1'b1, 1'b1, 1'b1,
                                       1'b1, 1'b1, 48'd2));
    queued_events.push_back(make_event(bsfa_pkg::KIND_DEPART, 14'd0, 1'b0, 1'b0, 1'b0,
                                       1'b0, 1'b0, 48'd3));
    queued_events.push_back(make_event(bsfa_pkg::KIND_DEPART, 14'h3FFF, 1'b0, 1'b0, 1'b0,
                                       1'b0, 1'b0, 48'd4));
    queued_events.push_back(make_event(bsfa_pkg::KIND_DEPART, 14'd5000, 1'b1, 1'b0, 1'b1,
                                       1'b0, 1'b1, 48'd5));
    drain();

    // A back-to-back run of PRU deposits, then a few increments that draw
    // the count back down.
    hurry = 1'b1;
    for (int i = 0; i < 16; i++)
      queued_events.push_back(make_event(bsfa_pkg::KIND_ARRIVAL, 14'd0, 1'b1, 1'b1, 1'b1,
                                         1'b0, 1'b0, 48'(i * 10)));
    for (int i = 0; i < 3; i++)
      queued_events.push_back(make_event(bsfa_pkg::KIND_ARRIVAL, 14'd0, 1'b1, 1'b1, 1'b0,
                                         1'b0, 1'b1, 48'(700000 + i)));
    drain();
    hurry = 1'b0;

    program_port(24'd20000, 24'd1500, 14'd1500, bsfa_pkg::RATE_RESET);
    random_phase(150, 3000);
    drain();
    program_port(24'hFFFFFF, 24'd0, 14'h3FFF, 32'hFFFF_FFFF);
    random_phase(150, 16383);
    drain();
    program_port(24'd0, 24'hFFFFFF, 14'd64, 32'd0);
    random_phase(80, 200);
    drain();
    // An MTU below the documented floor is taken as written.
    program_port(24'd8000, 24'hFFFFFF, 14'd10, 32'h8000_0000);
    random_phase(150, 1500);
    drain();
    program_port(24'd60000, 24'd4000, 14'd9000, 32'h0100_0000);
    random_phase(200, 9000);
    drain();
    program_port(24'd300000, 24'd1500, 14'd1500, bsfa_pkg::RATE_RESET);
    random_phase(140, 16383);
    drain();

    repeat (4) @(posedge clk);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
